// ===== hdl/fa_pkg.sv =====
`timescale 1ns / 1ps
package fa_pkg;

    // default geometry
    localparam int MAX_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // fixed field widths
    localparam int IDX_W  = 4;
    localparam int AMT_W  = 16;
    localparam int MODE_W = 2;
    localparam int BCNT_W = 5;
    localparam int CIDX_W = 1;
    localparam int CDAT_W = 5;
    localparam int DATA_W = 24;   // 4 + 16 bits, padded to bytes

    // opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // placement modes
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;   // places nothing

    // config register indexes
    localparam logic [CIDX_W-1:0] CFG_FIT_MODE    = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [BCNT_W-1:0] BCNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic capture;   // latch incoming word, clear search state
        logic issue;     // read next table entry
        logic finish;    // write back and load result register
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic issue_done;
        logic rd_pending;
        logic out_free;
    } t_sts;

endpackage

// ===== hdl/fa_ram.sv =====
`timescale 1ns / 1ps
module fa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/fa_ctrl.sv =====
`timescale 1ns / 1ps
module fa_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  fa_pkg::t_sts i_sts,
    output fa_pkg::t_cmd o_cmd
);
    import fa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.is_load) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.issue = !i_sts.issue_done;
                    if (i_sts.issue_done && !i_sts.rd_pending) begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("accepted word did not start processing");

    a_read_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.rd_pending |-> (r_state == S_SCAN))
        else $error("table read in flight outside scan");

    a_finish_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!i_sts.rd_pending && !o_cmd.issue))
        else $error("write back while a read is still in flight");

endmodule

// ===== hdl/fa_dpath.sv =====
`timescale 1ns / 1ps
module fa_dpath #(
    parameter int MAX_BLOCKS = fa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fa_pkg::SIZE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config
    input  logic                        i_cfg_we,
    input  logic [fa_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [fa_pkg::CDAT_W-1:0]   i_cfg_data,
    // input word
    input  logic                        i_opcode,
    input  logic [fa_pkg::IDX_W-1:0]    i_load_index,
    input  logic [fa_pkg::AMT_W-1:0]    i_amount,
    // result
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_granted,
    output logic [fa_pkg::IDX_W-1:0]    o_chosen_block,
    output logic [fa_pkg::AMT_W-1:0]    o_remaining_size,
    // control
    input  fa_pkg::t_cmd                i_cmd,
    output fa_pkg::t_sts                o_sts
);
    import fa_pkg::*;

    localparam int IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int LW   = (CW > BCNT_W) ? CW : BCNT_W;
    localparam int CMPW = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

    // config registers
    logic [MODE_W-1:0] r_mode;
    logic [BCNT_W-1:0] r_bcount;

    // latched word
    logic              r_op;
    logic [IDX_W-1:0]  r_idx;
    logic [AMT_W-1:0]  r_amt;

    // scan state
    logic [CW-1:0]         r_addr;
    logic                  r_rd_vld;
    logic [IW-1:0]         r_rd_idx;
    logic                  r_rd_ok;
    logic [MAX_BLOCKS-1:0] r_valid;
    logic                  r_found;
    logic [IW-1:0]         r_best_idx;
    logic [SIZE_BITS-1:0]  r_best_sz;

    // result register
    logic              r_out_valid;
    logic              r_out_grant;
    logic [IDX_W-1:0]  r_out_blk;
    logic [AMT_W-1:0]  r_out_rem;

    logic [LW-1:0]        bc_ext;
    logic [LW-1:0]        lim_ext;
    logic [CW-1:0]        lim;
    logic [SIZE_BITS-1:0] ram_q;
    logic [SIZE_BITS-1:0] sz;
    logic                 fits;
    logic                 take;
    logic [IW+IDX_W-1:0]  idx_wide;
    logic                 ld_ok;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [SIZE_BITS-1:0] wr_data;
    logic [CMPW-1:0]      diff;

    // search limit: block_count clipped to the table
    always_comb begin
        bc_ext  = LW'(r_bcount);
        lim_ext = (bc_ext > LW'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : bc_ext;
        lim     = CW'(lim_ext);
    end

    fa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (r_addr[IW-1:0]),
        .o_rdata (ram_q)
    );

    // compare stage; never-written entries read as zero
    always_comb begin
        sz   = r_rd_ok ? ram_q : '0;
        fits = r_rd_vld && (r_mode != MODE_UNUSED) && (CMPW'(sz) >= CMPW'(r_amt));
        take = 1'b0;
        if (fits) begin
            if (!r_found) begin
                take = 1'b1;
            end else if (r_mode == MODE_BEST) begin
                take = sz < r_best_sz;
            end else if (r_mode == MODE_WORST) begin
                take = sz > r_best_sz;
            end
        end
    end

    // write back
    always_comb begin
        idx_wide = {{IW{1'b0}}, r_idx};
        ld_ok    = (int'(r_idx) < MAX_BLOCKS);
        diff     = CMPW'(r_best_sz) - CMPW'(r_amt);
        if (r_op == OP_LOAD) begin
            wr_en   = i_cmd.finish && ld_ok;
            wr_addr = idx_wide[IW-1:0];
            wr_data = SIZE_BITS'(r_amt);
        end else begin
            wr_en   = i_cmd.finish && r_found;
            wr_addr = r_best_idx;
            wr_data = diff[SIZE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_FIRST;
            r_bcount <= BCNT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FIT_MODE:    r_mode   <= i_cfg_data[MODE_W-1:0];
                CFG_BLOCK_COUNT: r_bcount <= i_cfg_data[BCNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_idx <= i_load_index;
            r_amt <= i_amount;
        end
        r_rd_idx <= r_addr[IW-1:0];
        r_rd_ok  <= r_valid[r_addr[IW-1:0]];
        if (take) begin
            r_best_idx <= r_rd_idx;
            r_best_sz  <= sz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.capture) begin
                r_addr  <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (take) begin
                    r_found <= 1'b1;
                end
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_grant <= wr_en;
            r_out_blk   <= wr_en ? IDX_W'(wr_addr) : '0;
            r_out_rem   <= wr_en ? AMT_W'(wr_data) : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted        = r_out_grant;
    assign o_chosen_block   = r_out_blk;
    assign o_remaining_size = r_out_rem;

    assign o_sts.is_load    = (r_op == OP_LOAD);
    assign o_sts.issue_done = (r_addr == lim);
    assign o_sts.rd_pending = r_rd_vld;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> (r_addr < lim))
        else $error("table read beyond search limit");

    a_grant_has_fit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && r_op == OP_REQUEST && r_found) |->
            (CMPW'(r_best_sz) >= CMPW'(r_amt)))
        else $error("chosen block smaller than request");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=>
            (r_out_valid && $stable({r_out_grant, r_out_blk, r_out_rem})))
        else $error("stalled result word changed or dropped");

endmodule

// ===== hdl/fit_allocator.sv =====
`timescale 1ns / 1ps
// Free-block allocator: keeps the free size of MAX_BLOCKS blocks and places
// requests by first, best or worst fit.
//
// Input channel (s_axis): tuser = opcode (0 load, 1 request), tdata carries
// the block number for loads and the amount. A load writes one table entry;
// a request searches entries 0 .. N-1, N = min(block_count, MAX_BLOCKS), and
// takes the amount off the chosen block. Ties go to the lower block number.
// Output channel (m_axis): one word per input word; tuser = granted, tdata
// carries the block number and the size left in it (zeros when not granted).
// Config channel: index 0 fit_mode, index 1 block_count; always ready. The
// user must write it only while no word is in progress; the block does not
// enforce this. One word is in progress at a time. A load or an empty search
// goes straight to write-back; a request first reads entries 0 .. N-1
// through the registered table read, lets the last read drain, then writes
// back. The result is registered at write-back, and the input is ready again
// as the result appears. A stalled result stays in the output register and
// the write-back of the next word waits for it. Reset empties the table (all
// sizes zero), sets fit_mode to first fit and block_count to 16.
module fit_allocator #(
    parameter int MAX_BLOCKS = fa_pkg::MAX_BLOCKS_DEF,
    parameter int SIZE_BITS  = fa_pkg::SIZE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input words
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [fa_pkg::DATA_W-1:0]  s_axis_tdata,   // [3:0] load_index, [19:4] amount
    input  logic                       s_axis_tuser,   // [0] opcode
    // result words
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [fa_pkg::DATA_W-1:0]  m_axis_tdata,   // [3:0] chosen_block, [19:4] remaining_size
    output logic                       m_axis_tuser,   // [0] granted
    // configuration writes
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [fa_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [fa_pkg::CDAT_W-1:0]  i_cfg_data
);
    import fa_pkg::*;

    t_cmd             cmd;
    t_sts             sts;
    logic [IDX_W-1:0] chosen_block;
    logic [AMT_W-1:0] remaining_size;
    logic             granted;

    assign o_cfg_ready = 1'b1;

    fa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fa_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (s_axis_tuser),
        .i_load_index     (s_axis_tdata[IDX_W-1:0]),
        .i_amount         (s_axis_tdata[IDX_W+AMT_W-1:IDX_W]),
        .o_out_valid      (m_axis_tvalid),
        .i_out_ready      (m_axis_tready),
        .o_granted        (granted),
        .o_chosen_block   (chosen_block),
        .o_remaining_size (remaining_size),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

    // pack result word; upper pad bits are zero
    assign m_axis_tdata = {{(DATA_W-IDX_W-AMT_W){1'b0}}, remaining_size, chosen_block};
    assign m_axis_tuser = granted;

endmodule

// ===== verif/fit_allocator_tb.sv =====
`timescale 1ns / 1ps
module fit_allocator_tb;
    import fa_pkg::*;

    localparam int                NBLK        = MAX_BLOCKS_DEF;

    typedef struct packed {
        logic             granted;
        logic [IDX_W-1:0] blk;
        logic [AMT_W-1:0] rem;
    } t_placement;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    // clock, reset and block ports; every input starts at a known value
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata  = '0;   // [3:0] load_index, [19:4] amount
    logic                s_axis_tuser  = 1'b0; // [0] opcode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [DATA_W-1:0]   m_axis_tdata;         // [3:0] chosen_block, [19:4] remaining_size
    logic                m_axis_tuser;         // [0] granted
    logic                i_cfg_valid   = 1'b0;
    logic                o_cfg_ready;
    logic [CIDX_W-1:0]   i_cfg_index   = '0;
    logic [CDAT_W-1:0]   i_cfg_data    = '0;

    // predictor state: free sizes and the register shadow
    logic [AMT_W-1:0]    sh_sizes [NBLK];
    logic [MODE_W-1:0]   sh_mode;
    logic [BCNT_W-1:0]   sh_count;

    t_placement          placements_due [$];

    int                  errors        = 0;
    int                  words_sent    = 0;
    int                  results_seen  = 0;
    int                  grants_seen   = 0;
    int                  requests_sent = 0;
    int                  mode_words [4] = '{0, 0, 0, 0};

    // sender burst control
    bit                  tx_gaps    = 1'b0;
    int                  burst_left = 0;

    // receiver stall control
    t_rx_mode            rx_mode   = RX_OPEN;
    bit                  hold_req  = 1'b0;
    int                  hold_len  = 0;
    int                  hold_left = 0;
    int                  rx_tick   = 0;

    fit_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Placement predictor. Updates the shadow table exactly as the block
    // should for one accepted word and returns the word it must answer with.
    function automatic t_placement predict_placement(input logic op,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [AMT_W-1:0] amt);
        t_placement r;
        int         lim;
        int         pick;
        bit         found;
        bit         stop;
        r     = '0;
        pick  = 0;
        found = 1'b0;
        stop  = 1'b0;
        if (op == OP_LOAD) begin
            // load index is 4 bits wide, so it always lands inside the table
            sh_sizes[idx] = amt;
            r.granted = 1'b1;
            r.blk     = idx;
            r.rem     = amt;
            return r;
        end
        lim = (sh_count > NBLK) ? NBLK : int'(sh_count);
        if (sh_mode != MODE_UNUSED) begin
            for (int j = 0; j < lim; j++) begin
                if (!stop && sh_sizes[j] >= amt) begin
                    if (!found) begin
                        found = 1'b1;
                        pick  = j;
                        if (sh_mode == MODE_FIRST)
                            stop = 1'b1;
                    end else if (sh_mode == MODE_BEST && sh_sizes[j] < sh_sizes[pick]) begin
                        pick = j;
                    end else if (sh_mode == MODE_WORST && sh_sizes[j] > sh_sizes[pick]) begin
                        pick = j;
                    end
                end
            end
        end
        if (found) begin
            sh_sizes[pick] = sh_sizes[pick] - amt;
            r.granted = 1'b1;
            r.blk     = pick[IDX_W-1:0];
            r.rem     = sh_sizes[pick];
        end
        return r;
    endfunction

    // Receiver: own stall pattern, plus a long hold-off counted here.
    always @(posedge i_clk) begin
        rx_tick = rx_tick + 1;
        if (hold_req) begin
            hold_left = hold_len;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:     m_axis_tready <= 1'b1;
                RX_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:    m_axis_tready <= ($urandom_range(0, 9) < 3);
                RX_PERIODIC: m_axis_tready <= ((rx_tick % 7) < 4);
                default:     m_axis_tready <= 1'b1;
            endcase
        end
    end

    // Result checker: every accepted word against the oldest prediction.
    always @(posedge i_clk) begin
        t_placement exp_w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen = results_seen + 1;
            if (m_axis_tuser)
                grants_seen = grants_seen + 1;
            if (placements_due.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected result word, expected none, actual tuser %b tdata %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                exp_w = placements_due.pop_front();
                if (m_axis_tuser !== exp_w.granted) begin
                    errors = errors + 1;
                    $display("%0t: granted mismatch, expected %b actual %b",
                             $time, exp_w.granted, m_axis_tuser);
                end
                if (m_axis_tdata[3:0] !== exp_w.blk) begin
                    errors = errors + 1;
                    $display("%0t: chosen_block mismatch, expected %0d actual %0d",
                             $time, exp_w.blk, m_axis_tdata[3:0]);
                end
                if (m_axis_tdata[19:4] !== exp_w.rem) begin
                    errors = errors + 1;
                    $display("%0t: remaining_size mismatch, expected %h actual %h",
                             $time, exp_w.rem, m_axis_tdata[19:4]);
                end
                if (m_axis_tdata[DATA_W-1:20] !== '0) begin
                    errors = errors + 1;
                    $display("%0t: tdata padding mismatch, expected 0 actual %h",
                             $time, m_axis_tdata[DATA_W-1:20]);
                end
            end
        end
    end

    // Offer one word, wait for the handshake, record the prediction.
    // Returns either with tvalid still high (burst goes on) or after a gap;
    // in both cases no assignment to tvalid is pending in the current step.
    task automatic send_word(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [AMT_W-1:0] amt);
        t_placement exp_w;
        s_axis_tdata  <= {{(DATA_W-20){1'b0}}, amt, idx};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        exp_w = predict_placement(op, idx, amt);
        placements_due.push_back(exp_w);
        words_sent = words_sent + 1;
        if (op == OP_REQUEST) begin
            requests_sent = requests_sent + 1;
            mode_words[sh_mode] = mode_words[sh_mode] + 1;
        end
        if (tx_gaps) begin
            if (burst_left == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left = burst_left - 1;
            end
        end
    endtask

    // Stop offering and wait until every predicted word has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (placements_due.size() != 0) @(posedge i_clk);
        // extra wait so the engine is back in idle
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CIDX_W-1:0] index, input logic [CDAT_W-1:0] data);
        i_cfg_index <= index;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == CFG_FIT_MODE)
            sh_mode = data[MODE_W-1:0];
        else
            sh_count = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Both registers, only once the block has gone quiet.
    task automatic set_strategy(input logic [MODE_W-1:0] mode, input logic [BCNT_W-1:0] cnt);
        logic [CDAT_W-1:0] mode_word;
        drain_results();
        mode_word = CDAT_W'($urandom_range(0, 7)) << MODE_W;  // junk in unused bits
        mode_word[MODE_W-1:0] = mode;
        cfg_write(CFG_FIT_MODE, mode_word);
        cfg_write(CFG_BLOCK_COUNT, cnt);
    endtask

    function automatic logic [AMT_W-1:0] pick_request_amount();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1, 2:    return sh_sizes[$urandom_range(0, NBLK - 1)];   // exact fit, ties
            8:       return AMT_W'($urandom_range(1, 1024));
            9:       return AMT_W'($urandom);
            default: return AMT_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [AMT_W-1:0] pick_load_size();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            6:       return ($urandom_range(0, 1) != 0) ? {AMT_W{1'b1}} : '0;
            7:       return sh_sizes[$urandom_range(0, NBLK - 1)];   // duplicate size
            8, 9:    return AMT_W'($urandom);
            default: return AMT_W'($urandom_range(0, 200));
        endcase
    endfunction

    // Empty table after reset, then each strategy, the unused mode, an
    // empty search, a count beyond the table and a load outside the count.
    task automatic test_directed();
        sh_mode  = MODE_FIRST;
        sh_count = BCNT_RESET;
        foreach (sh_sizes[i]) sh_sizes[i] = '0;
        tx_gaps = 1'b0;
        rx_mode = RX_OPEN;
        send_word(OP_REQUEST, 4'd9, 16'd0);      // zero request on a size-0 block
        send_word(OP_REQUEST, 4'd0, 16'd1);      // nothing fits yet
        send_word(OP_LOAD, 4'd0, 16'd100);
        send_word(OP_LOAD, 4'd1, 16'd40);
        send_word(OP_LOAD, 4'd2, 16'd40);
        send_word(OP_LOAD, 4'd3, 16'hFFFF);
        send_word(OP_LOAD, 4'd15, 16'd40);
        send_word(OP_REQUEST, 4'd15, 16'd30);    // first fit -> block 0
        set_strategy(MODE_BEST, 5'd16);
        send_word(OP_REQUEST, 4'd0, 16'd40);     // three-way tie, lowest wins
        send_word(OP_REQUEST, 4'd0, 16'd40);
        set_strategy(MODE_WORST, 5'd16);
        send_word(OP_REQUEST, 4'd0, 16'hFFFF);   // exact fit of the full size
        send_word(OP_REQUEST, 4'd0, 16'd10);
        set_strategy(MODE_UNUSED, 5'd16);
        send_word(OP_REQUEST, 4'd0, 16'd1);      // places nothing
        send_word(OP_LOAD, 4'd5, 16'd7);         // loads still work
        set_strategy(MODE_FIRST, 5'd0);
        send_word(OP_REQUEST, 4'd0, 16'd0);      // empty search, even for zero
        set_strategy(MODE_BEST, 5'd31);
        send_word(OP_REQUEST, 4'd0, 16'd35);     // block 15 reachable -> best is 15
        set_strategy(MODE_FIRST, 5'd4);
        send_word(OP_LOAD, 4'd10, 16'd500);      // outside count, still written
        send_word(OP_REQUEST, 4'd0, 16'd200);    // not searched up there
        set_strategy(MODE_FIRST, 5'd17);
        send_word(OP_REQUEST, 4'd0, 16'd200);    // now block 10 takes it
        drain_results();
    endtask

    // Receiver holds off for a long stretch while words keep coming, so the
    // input stalls; afterwards the sender waits for everything to return.
    task automatic test_backpressure();
        set_strategy(MODE_WORST, 5'd16);
        tx_gaps   = 1'b0;
        rx_mode   = RX_LIGHT;
        hold_len  = 300;
        hold_req  = 1'b1;
        for (int i = 0; i < 12; i++)
            send_word(OP_LOAD, IDX_W'(i), AMT_W'($urandom_range(100, 4000)));
        for (int i = 0; i < 10; i++)
            send_word(OP_REQUEST, IDX_W'($urandom), AMT_W'($urandom_range(1, 300)));
        drain_results();
    endtask

    // One random phase: refill part of the table, then mostly requests with
    // some loads mixed in and a little full-range noise.
    task automatic run_phase(input int n_items, input bit pause_mid);
        int nload;
        int kind;
        nload = $urandom_range(2, 10);
        for (int i = 0; i < nload; i++)
            send_word(OP_LOAD, IDX_W'($urandom_range(0, NBLK - 1)), pick_load_size());
        for (int i = nload; i < n_items; i++) begin
            if (pause_mid && i == n_items / 2)
                drain_results();
            kind = $urandom_range(0, 19);
            if (kind < 15)
                send_word(OP_REQUEST, IDX_W'($urandom), pick_request_amount());
            else if (kind < 18)
                send_word(OP_LOAD, IDX_W'($urandom_range(0, NBLK - 1)), pick_load_size());
            else
                send_word(logic'($urandom_range(0, 1)), IDX_W'($urandom), AMT_W'($urandom));
        end
    endtask

    task automatic test_random_phases();
        logic [MODE_W-1:0] mode;
        logic [BCNT_W-1:0] cnt;
        for (int p = 0; p < 11; p++) begin
            case (p % 4)
                0:       mode = MODE_FIRST;
                1:       mode = MODE_BEST;
                2:       mode = MODE_WORST;
                default: mode = (p == 7) ? MODE_UNUSED : MODE_BEST;
            endcase
            case (p)
                0, 4, 8: cnt = 5'd16;
                1:       cnt = 5'd1;
                2:       cnt = 5'd31;
                5:       cnt = 5'd0;
                6:       cnt = 5'd17;
                default: cnt = BCNT_W'($urandom_range(2, 31));
            endcase
            set_strategy(mode, cnt);
            // phase 0 runs with no idling on either side
            tx_gaps = (p != 0);
            rx_mode = (p == 0) ? RX_OPEN : t_rx_mode'(p % 4);
            burst_left = $urandom_range(1, 12);
            run_phase(55, p % 3 == 1);
        end
        // back to the reset count with a full-width mode word
        set_strategy(MODE_FIRST, BCNT_RESET);
        tx_gaps = 1'b1;
        rx_mode = RX_HEAVY;
        run_phase(20, 1'b0);
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_phases();
        // tail: make sure nothing extra falls out
        repeat (40) @(posedge i_clk);
        if (placements_due.size() != 0) begin
            errors = errors + 1;
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, placements_due.size());
        end
        $display("Run covered %0d words (%0d requests), %0d results back, %0d granted.",
                 words_sent, requests_sent, results_seen, grants_seen);
        $display("Requests by strategy: first %0d, best %0d, worst %0d, unused %0d.",
                 mode_words[0], mode_words[1], mode_words[2], mode_words[3]);
        if (errors == 0)
            $display("** fit_allocator: PASSED **");
        else
            $display("** fit_allocator: FAILED **");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("Timeout with %0d results outstanding.", placements_due.size());
        $display("** fit_allocator: FAILED **");
        $finish;
    end

endmodule
